// ===== hdl/swbq_pkg.sv =====
package swbq_pkg;

  // default build sizes
  localparam int MAX_WINDOW_DEF  = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // field and register widths
  localparam int CFG_W   = 11;
  localparam int CODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int VW_W    = 32;
  localparam int NUM_BASES = 4;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_A      = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_C      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_G      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_T      = 3'd4;

  // symbol codes for the four bases; anything with bit 2 set is another symbol
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  // request in flight between ring access and count update
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              evict;
    logic              full;
    logic              last;
  } stage_t;

endpackage

// ===== hdl/swbq_ram.sv =====
module swbq_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first when both ports hit the same entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sliding_window_base_quota_counter.sv =====
// Sliding window base quota counter.
// Input channel: base_code_i/end_of_string_i qualified by in_valid_i, held off by
// in_stall_o. One symbol a cycle is taken when the result side keeps up.
// Output channel: window_full_o, window_ok_o and valid_windows_o qualified by
// out_valid_o, held off by out_stall_i. Exactly one result per symbol, in order.
// Pipeline: the ring read is registered with the symbol in the count stage, then
// the count update is registered into the output register. Throughput: one
// symbol per cycle while out_stall_i stays low, set by the ring access (one write
// and one read of the ring memory per symbol) and the count update. A stalled
// result sits in the output register while one more symbol waits in the count
// stage; only then is in_stall_o raised. Configuration: cfg_we_i writes register
// cfg_index_i; the user writes only while the block is idle, which the block does
// not enforce. Writing the window length restarts the string: window, counts and
// total clear. End of string: the result of the flagged symbol is delivered, then
// the window, counts and total clear. Reset clears all control state, sets the
// window length to 1 and all minimums to 0; the ring needs no clearing since it is
// only read at entries written in the current string.
module sliding_window_base_quota_counter
  import swbq_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CODE_W-1:0] base_code_i,
  input  logic              end_of_string_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              window_full_o,
  output logic              window_ok_o,
  output logic [VW_W-1:0]   valid_windows_o
);

  localparam int LW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW = LW + 1;
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam int EW = CW + 1;

  // configuration
  logic [LW-1:0]    len_q;
  logic [CFG_W-1:0] min_q [NUM_BASES];
  logic [LW-1:0]    len_d;
  logic [EW-1:0]    cfg_ext;
  logic             restart;

  // front stage state
  logic [AW-1:0] wp_q, wp_d;
  logic [LW-1:0] fill_q, fill_d;
  logic [LW-1:0] fill_inc;
  logic [PW-1:0] old_pos;
  logic [AW-1:0] old_addr;
  logic          evict;
  logic          in_accept;

  // count stage
  stage_t        s1_q;
  logic          s1_valid_q;
  logic          s1_adv;
  logic [CODE_W-1:0] old_code;
  logic [LW-1:0] cnt_q [NUM_BASES];
  logic [LW-1:0] cnt_d [NUM_BASES];
  logic          ok_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;

  // output register
  logic                   out_valid_q;
  logic                   out_full_q;
  logic                   out_ok_q;
  logic [COUNT_WIDTH-1:0] out_total_q;

  assign restart = cfg_we_i && (cfg_index_i == REG_WINDOW_LEN);

  // window length zero acts as one, above the ring size it saturates
  always_comb begin
    cfg_ext = EW'(cfg_data_i);
    if (cfg_data_i == '0) begin
      len_d = LW'(1);
    end else if (cfg_ext > EW'(MAX_WINDOW)) begin
      len_d = LW'(MAX_WINDOW);
    end else begin
      len_d = cfg_ext[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LW'(1);
      for (int b = 0; b < NUM_BASES; b++) begin
        min_q[b] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LEN: len_q    <= len_d;
        REG_MIN_A:      min_q[0] <= cfg_data_i;
        REG_MIN_C:      min_q[1] <= cfg_data_i;
        REG_MIN_G:      min_q[2] <= cfg_data_i;
        REG_MIN_T:      min_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // front stage: write the new symbol, read the one leaving the window
  assign evict    = (fill_q == len_q);
  assign fill_inc = fill_q + LW'(1);

  always_comb begin
    if (PW'(wp_q) >= PW'(len_q)) begin
      old_pos = PW'(wp_q) - PW'(len_q);
    end else begin
      old_pos = PW'(wp_q) + PW'(MAX_WINDOW) - PW'(len_q);
    end
    old_addr = old_pos[AW-1:0];
  end

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (restart) begin
      wp_d   = '0;
      fill_d = '0;
    end else if (in_accept) begin
      if (end_of_string_i) begin
        wp_d   = '0;
        fill_d = '0;
      end else begin
        wp_d   = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
        fill_d = evict ? fill_q : fill_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  swbq_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wp_q),
    .wdata_i (base_code_i),
    .re_i    (in_accept),
    .raddr_i (old_addr),
    .rdata_o (old_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.code  <= base_code_i;
      s1_q.evict <= evict;
      s1_q.full  <= evict || (fill_inc == len_q);
      s1_q.last  <= end_of_string_i;
    end
  end

  // count stage: bit 2 of a code marks a symbol that counts as no base
  always_comb begin
    logic inc;
    logic dec;
    ok_d = s1_q.full;
    for (int b = 0; b < NUM_BASES; b++) begin
      inc = !s1_q.code[2] && (s1_q.code[1:0] == 2'(b));
      dec = s1_q.evict && !old_code[2] && (old_code[1:0] == 2'(b));
      cnt_d[b] = cnt_q[b] + LW'(inc) - LW'(dec);
      if (CW'(cnt_d[b]) < CW'(min_q[b])) begin
        ok_d = 1'b0;
      end
    end
    if (ok_d && (total_q != '1)) begin
      total_d = total_q + COUNT_WIDTH'(1);
    end else begin
      total_d = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BASES; b++) begin
        cnt_q[b] <= '0;
      end
      total_q <= '0;
    end else if (restart) begin
      for (int b = 0; b < NUM_BASES; b++) begin
        cnt_q[b] <= '0;
      end
      total_q <= '0;
    end else if (s1_adv) begin
      for (int b = 0; b < NUM_BASES; b++) begin
        cnt_q[b] <= s1_q.last ? '0 : cnt_d[b];
      end
      total_q <= s1_q.last ? '0 : total_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_full_q  <= s1_q.full;
      out_ok_q    <= ok_d;
      out_total_q <= total_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign window_full_o   = out_full_q;
  assign window_ok_o     = out_ok_q;
  assign valid_windows_o = VW_W'(out_total_q);

endmodule
